FILE: hw/rtl/two_axis_stepper_segment_driver_macros.svh
// Assertion helpers for the top-level driver RTL file.
`ifndef TWO_AXIS_STEPPER_SEGMENT_DRIVER_MACROS_SVH
`define TWO_AXIS_STEPPER_SEGMENT_DRIVER_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define TASS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("two_axis_stepper_segment_driver: assertion failed");
// Check that a condition is followed by another in the next cycle.
`define TASS_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
		else $error("two_axis_stepper_segment_driver: sequence check failed");
`else
`define TASS_ASSERT(lbl, clk, rst_n, prop)
`define TASS_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt)
`endif

`endif

FILE: hw/rtl/tass_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tass_pkg;

	localparam int unsigned STEP_BITS_DEF = 16;
	localparam int unsigned TAU_W         = 16;
	localparam int unsigned PERIOD_W      = 32;
	localparam logic [TAU_W-1:0] MIN_TAU_RESET = 16'd2000;

	// Register index of min_tau in the configuration space
	localparam logic REG_MIN_TAU = 1'b0;

	// Request kinds carried in tuser
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_LOAD = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_EMIT
	} drv_state_t;

	typedef enum logic [2:0] {
		PS_IDLE,
		PS_MUL,
		PS_NUM,
		PS_DIV,
		PS_RES,
		PS_DONE
	} period_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} period_stat_t;

	// Full-step coil pattern for a phase
	function automatic logic [3:0] coil_pattern(input logic [1:0] ph);
		logic [7:0] p;
		p = 8'h33 >> ph;
		return p[3:0];
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/two_axis_stepper_segment_driver.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Bus                      Contents
// s_axis    in   s_tdata[31:0], s_tuser   seg_dx, seg_dy; tuser = req_type
// m_axis    out  m_tdata[15:0]            port_byte, busy_res, accepted
// apb       in   paddr[2:0], pwdata[31:0] min_tau at byte address 0
//
// A tick request is resolved at its accepting edge: its result is valid in the next cycle.
// A segment load runs the period unit: a shift-add multiply, the rounded numerator, a
// restoring divide and the result step (straight to done with no minor steps).
// A load refused while busy answers at once.
// Reset clears all axis state and sets min_tau to 2000; no clearing pass.
// A result waiting on m_tready holds off every further request.
`include "two_axis_stepper_segment_driver_macros.svh"
module two_axis_stepper_segment_driver #(
	parameter int unsigned STEP_BITS = tass_pkg::STEP_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [15:0] seg_dx, [31:16] seg_dy
	input  wire logic [0:0]  s_tuser,   // [0] req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata,   // [7:0] port_byte, [8] busy_res, [9] accepted
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int unsigned MW = (STEP_BITS > 17) ? STEP_BITS : 17;
	localparam logic [MW-1:0] STEP_MAX = MW'((64'd1 << STEP_BITS) - 64'd1);
	localparam int unsigned PERW = tass_pkg::PERIOD_W;

	tass_pkg::drv_state_t state_q, state_d;

	logic [tass_pkg::TAU_W-1:0] min_tau_q;
	logic [1:0]                 ph_x_q, ph_y_q;
	logic [STEP_BITS-1:0]       rem_x_q, rem_y_q;
	logic                       dir_x_q, dir_y_q;
	logic [PERW-1:0]            per_x_q, per_y_q;
	logic [PERW-1:0]            cd_x_q, cd_y_q;
	logic [7:0]                 port_q;
	logic                       y_major_q;
	logic                       m_tvalid_q;
	logic [15:0]                m_tdata_q;

	// Configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_tau_q <= tass_pkg::MIN_TAU_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == tass_pkg::REG_MIN_TAU) begin
			min_tau_q <= pwdata[tass_pkg::TAU_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == tass_pkg::REG_MIN_TAU) ? 32'(min_tau_q) : 32'd0;

	// Magnitudes and saturation of the step counts
	logic [16:0]          m17_x, m17_y;
	logic [MW-1:0]        mw_x, mw_y;
	logic [STEP_BITS-1:0] ax, ay;
	logic                 y_major;
	logic [tass_pkg::TAU_W-1:0] tau_eff;

	always_comb begin
		m17_x   = s_tdata[15] ? (17'h10000 - {1'b0, s_tdata[15:0]}) : {1'b0, s_tdata[15:0]};
		m17_y   = s_tdata[31] ? (17'h10000 - {1'b0, s_tdata[31:16]}) : {1'b0, s_tdata[31:16]};
		mw_x    = MW'(m17_x);
		mw_y    = MW'(m17_y);
		ax      = (mw_x > STEP_MAX) ? STEP_MAX[STEP_BITS-1:0] : mw_x[STEP_BITS-1:0];
		ay      = (mw_y > STEP_MAX) ? STEP_MAX[STEP_BITS-1:0] : mw_y[STEP_BITS-1:0];
		y_major = (ay > ax);
		tau_eff = (min_tau_q == '0) ? tass_pkg::TAU_W'(1) : min_tau_q;
	end

	// Request handshake
	logic slot_free, s_acc, is_load, busy_now, load_go;

	assign slot_free = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == tass_pkg::ST_IDLE) && slot_free;
	assign s_acc     = s_tvalid && s_tready;
	assign is_load   = (s_tuser[0] == tass_pkg::REQ_LOAD);
	assign busy_now  = (rem_x_q != '0) || (cd_x_q != '0) || (rem_y_q != '0) || (cd_y_q != '0);
	assign load_go   = s_acc && is_load && !busy_now;

	// Tick: step each axis that is due, else count down
	logic                 step_x, step_y;
	logic [7:0]           nport;
	logic [1:0]           nph_x, nph_y;
	logic [STEP_BITS-1:0] nrem_x, nrem_y;
	logic [PERW-1:0]      ncd_x, ncd_y;
	logic                 busy_tick;

	always_comb begin
		step_x = (rem_x_q != '0) && (cd_x_q == '0);
		step_y = (rem_y_q != '0) && (cd_y_q == '0);
		nport  = port_q;
		nph_x  = ph_x_q;
		nph_y  = ph_y_q;
		nrem_x = rem_x_q;
		nrem_y = rem_y_q;
		ncd_x  = (cd_x_q != '0) ? cd_x_q - PERW'(1) : cd_x_q;
		ncd_y  = (cd_y_q != '0) ? cd_y_q - PERW'(1) : cd_y_q;
		if (step_x) begin
			nport[3:0] = tass_pkg::coil_pattern(ph_x_q);
			nph_x      = dir_x_q ? ph_x_q - 2'd1 : ph_x_q + 2'd1;
			nrem_x     = rem_x_q - STEP_BITS'(1);
			ncd_x      = per_x_q - PERW'(1);
		end
		if (step_y) begin
			nport[7:4] = tass_pkg::coil_pattern(ph_y_q);
			nph_y      = dir_y_q ? ph_y_q - 2'd1 : ph_y_q + 2'd1;
			nrem_y     = rem_y_q - STEP_BITS'(1);
			ncd_y      = per_y_q - PERW'(1);
		end
		busy_tick = (nrem_x != '0) || (ncd_x != '0) || (nrem_y != '0) || (ncd_y != '0);
	end

	// Minor period unit
	logic [PERW-1:0]        minor_per;
	tass_pkg::period_stat_t pstat;

	tass_period #(
		.STEP_BITS (STEP_BITS)
	) u_period (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (load_go),
		.maj    (y_major ? ay : ax),
		.mnr    (y_major ? ax : ay),
		.tau    (tau_eff),
		.period (minor_per),
		.stat   (pstat)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tass_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tass_pkg::ST_IDLE: if (load_go) state_d = tass_pkg::ST_CALC;
			tass_pkg::ST_CALC: if (pstat.done) state_d = tass_pkg::ST_EMIT;
			tass_pkg::ST_EMIT: if (slot_free) state_d = tass_pkg::ST_IDLE;
			default:           state_d = tass_pkg::ST_IDLE;
		endcase
	end

	// Axis state: commit ticks, take segments, capture the minor period
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_x_q    <= '0;
			ph_y_q    <= '0;
			rem_x_q   <= '0;
			rem_y_q   <= '0;
			dir_x_q   <= 1'b0;
			dir_y_q   <= 1'b0;
			per_x_q   <= '0;
			per_y_q   <= '0;
			cd_x_q    <= '0;
			cd_y_q    <= '0;
			port_q    <= '0;
			y_major_q <= 1'b0;
		end else begin
			if (s_acc && !is_load) begin
				ph_x_q  <= nph_x;
				ph_y_q  <= nph_y;
				rem_x_q <= nrem_x;
				rem_y_q <= nrem_y;
				cd_x_q  <= ncd_x;
				cd_y_q  <= ncd_y;
				port_q  <= nport;
			end else if (load_go) begin
				dir_x_q   <= s_tdata[15];
				dir_y_q   <= s_tdata[31];
				rem_x_q   <= ax;
				rem_y_q   <= ay;
				cd_x_q    <= '0;
				cd_y_q    <= '0;
				y_major_q <= y_major;
				if (y_major) begin
					per_y_q <= PERW'(tau_eff);
				end else begin
					per_x_q <= PERW'(tau_eff);
				end
			end
			if (pstat.done) begin
				if (y_major_q) begin
					per_x_q <= minor_per;
				end else begin
					per_y_q <= minor_per;
				end
			end
		end
	end

	// Result register
	logic        out_we;
	logic [15:0] out_d;

	always_comb begin
		out_we = 1'b0;
		out_d  = m_tdata_q;
		if (s_acc && !is_load) begin
			out_we = 1'b1;
			out_d  = {6'd0, 1'b0, busy_tick, nport};
		end else if (s_acc && is_load && busy_now) begin
			out_we = 1'b1;
			out_d  = {6'd0, 1'b0, 1'b1, port_q};
		end else if (state_q == tass_pkg::ST_EMIT && slot_free) begin
			out_we = 1'b1;
			out_d  = {6'd0, 1'b1, busy_now, port_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_we) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_we) m_tdata_q <= out_d;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Checks
	`TASS_ASSERT(a_idle_unit, clk, arst_n, s_tready |-> !pstat.busy)
	`TASS_ASSERT(a_done_in_calc, clk, arst_n, pstat.done |-> (state_q == tass_pkg::ST_CALC))
	`TASS_ASSERT_NEXT(a_load_blocks, clk, arst_n, load_go, !s_tready)

endmodule
`default_nettype wire

FILE: hw/rtl/tass_period.sv
`timescale 1ns / 1ps
`default_nettype none
// Minor axis period: round(maj * tau / mnr), halves up, saturated to 32 bits.
// Shift-add multiply one tau bit a cycle, then restoring divide one bit a cycle.
module tass_period #(
	parameter int unsigned STEP_BITS = tass_pkg::STEP_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [STEP_BITS-1:0]            maj,
	input  wire logic [STEP_BITS-1:0]            mnr,
	input  wire logic [tass_pkg::TAU_W-1:0]      tau,
	output logic      [tass_pkg::PERIOD_W-1:0]   period,
	output tass_pkg::period_stat_t               stat
);

	localparam int unsigned PW = STEP_BITS + tass_pkg::TAU_W;
	localparam int unsigned NW = PW + 1;
	localparam int unsigned QW = (NW > 33) ? NW : 33;
	localparam int unsigned DW = STEP_BITS + 1;
	localparam int unsigned CW = $clog2(NW + 1);

	tass_pkg::period_state_t state_q, state_d;

	logic [CW-1:0]                   cnt_q;
	logic [PW-1:0]                   mcand_q;
	logic [tass_pkg::TAU_W-1:0]      mplier_q;
	logic [PW-1:0]                   acc_q;
	logic [STEP_BITS-1:0]            mnr_q;
	logic [NW-1:0]                   quo_q;
	logic [DW-1:0]                   rem_q;
	logic [tass_pkg::PERIOD_W-1:0]   period_q;

	logic [DW:0]   shifted;
	logic [DW+1:0] diff;
	logic          borrow;
	logic [QW-1:0] quo_ext;
	logic          sat;

	// Trial subtraction of twice the minor count
	always_comb begin
		shifted = {rem_q, quo_q[NW-1]};
		diff    = {1'b0, shifted} - {2'b00, mnr_q, 1'b0};
		borrow  = diff[DW+1];
		quo_ext = QW'(quo_q);
		sat     = |quo_ext[QW-1:tass_pkg::PERIOD_W];
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tass_pkg::PS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tass_pkg::PS_IDLE: begin
				if (start) begin
					state_d = (mnr == '0) ? tass_pkg::PS_DONE : tass_pkg::PS_MUL;
				end
			end
			tass_pkg::PS_MUL: begin
				if (cnt_q == CW'(tass_pkg::TAU_W - 1)) state_d = tass_pkg::PS_NUM;
			end
			tass_pkg::PS_NUM: state_d = tass_pkg::PS_DIV;
			tass_pkg::PS_DIV: begin
				if (cnt_q == CW'(NW - 1)) state_d = tass_pkg::PS_RES;
			end
			tass_pkg::PS_RES:  state_d = tass_pkg::PS_DONE;
			tass_pkg::PS_DONE: state_d = tass_pkg::PS_IDLE;
			default:           state_d = tass_pkg::PS_IDLE;
		endcase
	end

	// Multiply, build the rounded numerator, divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (state_q)
				tass_pkg::PS_IDLE: begin
					cnt_q <= '0;
				end
				tass_pkg::PS_MUL, tass_pkg::PS_DIV: begin
					cnt_q <= cnt_q + CW'(1);
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tass_pkg::PS_IDLE: begin
				if (start) begin
					mcand_q  <= PW'(maj);
					mplier_q <= tau;
					acc_q    <= '0;
					mnr_q    <= mnr;
					period_q <= tass_pkg::PERIOD_W'(tau);
				end
			end
			tass_pkg::PS_MUL: begin
				if (mplier_q[0]) acc_q <= acc_q + mcand_q;
				mcand_q  <= {mcand_q[PW-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[tass_pkg::TAU_W-1:1]};
			end
			tass_pkg::PS_NUM: begin
				quo_q <= {acc_q, 1'b0} + NW'(mnr_q);
				rem_q <= '0;
			end
			tass_pkg::PS_DIV: begin
				if (!borrow) begin
					rem_q <= diff[DW-1:0];
				end else begin
					rem_q <= shifted[DW-1:0];
				end
				quo_q <= {quo_q[NW-2:0], !borrow};
			end
			tass_pkg::PS_RES: begin
				period_q <= sat ? '1 : quo_ext[tass_pkg::PERIOD_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign period    = period_q;
	assign stat.busy = (state_q != tass_pkg::PS_IDLE);
	assign stat.done = (state_q == tass_pkg::PS_DONE);

endmodule
`default_nettype wire

FILE: test/tb_two_axis_stepper_segment_driver.sv
`timescale 1ns / 1ps
module tb_two_axis_stepper_segment_driver;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [15:0] seg_dx, [31:16] seg_dy
	logic [0:0]  s_tuser;   // [0] req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [7:0] port_byte, [8] busy_res, [9] accepted
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	two_axis_stepper_segment_driver dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	typedef struct packed {
		logic [7:0] port_byte;
		logic       busy_res;
		logic       accepted;
	} coil_result_t;

	coil_result_t expected_coils[$];
	int           mismatch_count = 0;
	int           sent_count     = 0;
	int           send_idle_pct  = 0;
	int           recv_stall_pct = 0;
	bit           hold_request   = 0;

	// Own copy of the axis state, after reset
	logic [15:0] tau_reg = tass_pkg::MIN_TAU_RESET;
	logic [1:0]  ph_x = '0, ph_y = '0;
	logic [15:0] left_x = '0, left_y = '0;
	logic        neg_x = 1'b0, neg_y = 1'b0;
	logic [31:0] per_x = '0, per_y = '0;
	logic [31:0] cnt_x = '0, cnt_y = '0;
	logic [7:0]  latch = '0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Overall time limit
	initial begin
		#2_000_000;
		$display("two_axis_stepper_segment_driver verification failed");
		$finish;
	end

	function automatic logic [3:0] coil_bits(input logic [1:0] ph);
		case (ph)
			2'd0: return 4'h3;
			2'd1: return 4'h9;
			2'd2: return 4'hC;
			default: return 4'h6;
		endcase
	endfunction

	function automatic logic [15:0] step_count(input logic [15:0] raw, output logic neg);
		neg = raw[15];
		return raw[15] ? 16'(-raw) : raw;
	endfunction

	// Rounded period of the slower axis, halves up
	function automatic logic [31:0] slow_period(input logic [15:0] maj, input logic [15:0] mnr,
			input logic [15:0] tau);
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] q;
		if (mnr == 16'd0)
			return {16'd0, tau};
		num = 64'(maj) * 64'(tau) * 64'd2 + 64'(mnr);
		den = 64'(mnr) * 64'd2;
		q = num / den;
		if (q > 64'hFFFF_FFFF)
			q = 64'hFFFF_FFFF;
		return q[31:0];
	endfunction

	function automatic bit stepper_busy();
		return left_x != 0 || cnt_x != 0 || left_y != 0 || cnt_y != 0;
	endfunction

	// Advance the local axis state by one request and return the expected result
	function automatic coil_result_t predict_request(input logic req, input logic [15:0] dx,
			input logic [15:0] dy);
		coil_result_t r;
		logic [15:0]  tau;
		logic [15:0]  ax;
		logic [15:0]  ay;
		r.accepted = 1'b0;
		if (req == tass_pkg::REQ_LOAD) begin
			if (!stepper_busy()) begin
				tau = (tau_reg == 16'd0) ? 16'd1 : tau_reg;
				ax = step_count(dx, neg_x);
				ay = step_count(dy, neg_y);
				if (ay > ax) begin
					per_y = {16'd0, tau};
					per_x = slow_period(ay, ax, tau);
				end else begin
					per_x = {16'd0, tau};
					per_y = slow_period(ax, ay, tau);
				end
				left_x = ax;
				left_y = ay;
				cnt_x = '0;
				cnt_y = '0;
				r.accepted = 1'b1;
			end
		end else begin
			if (left_x != 0 && cnt_x == 0) begin
				latch[3:0] = coil_bits(ph_x);
				ph_x = neg_x ? ph_x - 2'd1 : ph_x + 2'd1;
				left_x = left_x - 16'd1;
				cnt_x = per_x - 32'd1;
			end else if (cnt_x != 0) begin
				cnt_x = cnt_x - 32'd1;
			end
			if (left_y != 0 && cnt_y == 0) begin
				latch[7:4] = coil_bits(ph_y);
				ph_y = neg_y ? ph_y - 2'd1 : ph_y + 2'd1;
				left_y = left_y - 16'd1;
				cnt_y = per_y - 32'd1;
			end else if (cnt_y != 0) begin
				cnt_y = cnt_y - 32'd1;
			end
		end
		r.port_byte = latch;
		r.busy_res = stepper_busy();
		return r;
	endfunction

	function automatic logic [15:0] small_steps(input int lim);
		int v;
		v = int'($urandom_range(2 * lim)) - lim;
		return 16'(v);
	endfunction

	// Receiver: random stalls, or a long hold-off counted here
	always @(posedge clk) begin
		int hold_left;
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= (int'($urandom_range(99)) >= recv_stall_pct);
		end
	end

	// Compare each result with the oldest expectation
	always @(posedge clk) begin
		coil_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_coils.size() == 0) begin
				$display("%0t: unexpected result, actual %h", $time, m_tdata);
				mismatch_count++;
			end else begin
				exp_r = expected_coils.pop_front();
				if (m_tdata[7:0] !== exp_r.port_byte) begin
					$display("%0t: port_byte expected %h actual %h", $time,
						exp_r.port_byte, m_tdata[7:0]);
					mismatch_count++;
				end
				if (m_tdata[8] !== exp_r.busy_res) begin
					$display("%0t: busy_res expected %b actual %b", $time,
						exp_r.busy_res, m_tdata[8]);
					mismatch_count++;
				end
				if (m_tdata[9] !== exp_r.accepted) begin
					$display("%0t: accepted expected %b actual %b", $time,
						exp_r.accepted, m_tdata[9]);
					mismatch_count++;
				end
			end
		end
	end

	// Offer one request and wait for it to be taken
	task automatic send_req(input logic req, input logic [15:0] dx, input logic [15:0] dy);
		coil_result_t new_exp;
		while (int'($urandom_range(99)) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {dy, dx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		new_exp = predict_request(req, dx, dy);
		expected_coils.insert(expected_coils.size(), new_exp);
		sent_count++;
	endtask

	// Drop valid and wait for every outstanding result
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_coils.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_min_tau(input logic [15:0] value);
		drain_results();
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {tass_pkg::REG_MIN_TAU, 2'b00};
		pwdata  <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tau_reg = value;
	endtask

	// Load a segment and tick it to the end, with refused loads mixed in
	task automatic run_segment(input logic [15:0] dx, input logic [15:0] dy,
			input int refuse_pct);
		send_req(tass_pkg::REQ_LOAD, dx, dy);
		while (stepper_busy()) begin
			if (int'($urandom_range(99)) < refuse_pct)
				send_req(tass_pkg::REQ_LOAD, 16'($urandom), 16'($urandom));
			else
				send_req(tass_pkg::REQ_TICK, 16'($urandom), 16'($urandom));
		end
		send_req(tass_pkg::REQ_TICK, 16'($urandom), 16'($urandom));
	endtask

	task automatic test_idle_after_reset();
		send_req(tass_pkg::REQ_TICK, 16'h0000, 16'h0000);
		send_req(tass_pkg::REQ_LOAD, 16'h0000, 16'h0000);
		send_req(tass_pkg::REQ_TICK, 16'hFFFF, 16'hFFFF);
		drain_results();
	endtask

	task automatic test_directed_segments();
		write_min_tau(16'd1);
		// halves round up: 3 over 2 gives 2
		run_segment(16'd3, 16'd2, 0);
		// tie goes to X, opposite directions
		run_segment(-16'sd4, 16'd4, 0);
		write_min_tau(16'd3);
		// Y major, refused loads on the way
		run_segment(16'd1, 16'd5, 30);
		run_segment(16'd0, -16'sd3, 0);
		drain_results();
	endtask

	task automatic test_tau_extremes();
		// zero period acts as one
		write_min_tau(16'd0);
		run_segment(16'd2, -16'sd1, 0);
		write_min_tau(16'hFFFF);
		send_req(tass_pkg::REQ_LOAD, 16'd0, 16'd0);
		send_req(tass_pkg::REQ_TICK, 16'd0, 16'd0);
		drain_results();
	endtask

	task automatic test_long_segment();
		write_min_tau(16'd1);
		// long backwards run on X; extreme step counts offered while busy
		send_req(tass_pkg::REQ_LOAD, -16'sd100, 16'd3);
		send_req(tass_pkg::REQ_LOAD, 16'h7FFF, 16'h8000);
		send_req(tass_pkg::REQ_LOAD, 16'h8000, 16'h7FFF);
		while (stepper_busy()) begin
			if (int'($urandom_range(999)) < 5)
				send_req(tass_pkg::REQ_LOAD, 16'($urandom), 16'($urandom));
			else
				send_req(tass_pkg::REQ_TICK, 16'($urandom), 16'($urandom));
		end
		send_req(tass_pkg::REQ_TICK, 16'd0, 16'd0);
		drain_results();
	endtask

	task automatic test_back_pressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_min_tau(16'd2);
		hold_request = 1'b1;
		run_segment(16'd9, -16'sd6, 10);
		run_segment(16'd0, 16'd0, 0);
		drain_results();
	endtask

	task automatic test_random_traffic(input int send_pct, input int stall_pct,
			input logic [15:0] tau, input int n_items);
		int start;
		int pick;
		int lim;
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		write_min_tau(tau);
		lim = (tau <= 16'd1) ? 40 : 6;
		start = sent_count;
		while (sent_count - start < n_items) begin
			pick = int'($urandom_range(99));
			if (pick < 75)
				run_segment(small_steps(lim), small_steps(lim), 8);
			else if (pick < 85)
				send_req(tass_pkg::REQ_TICK, 16'($urandom), 16'($urandom));
			else if (pick < 92)
				send_req(tass_pkg::REQ_LOAD, 16'd0, 16'd0);
			else begin
				// broken sequence: load, up to three ticks, then a new load
				send_req(tass_pkg::REQ_LOAD, small_steps(lim), small_steps(lim));
				repeat ($urandom_range(3))
					send_req(tass_pkg::REQ_TICK, 16'($urandom), 16'($urandom));
				send_req(tass_pkg::REQ_LOAD, small_steps(lim), small_steps(lim));
				while (stepper_busy())
					send_req(tass_pkg::REQ_TICK, 16'($urandom), 16'($urandom));
			end
		end
		drain_results();
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_after_reset();
		test_directed_segments();
		test_tau_extremes();
		test_long_segment();
		test_back_pressure();
		test_random_traffic(0, 0, 16'd1, 320);
		test_random_traffic(61, 0, 16'd3, 320);
		test_random_traffic(0, 61, 16'd0, 320);
		test_random_traffic(7, 7, 16'd7, 320);

		// Let any stray result show up before the verdict
		drain_results();
		repeat (100) @(posedge clk);
		if (expected_coils.size() != 0)
			$display("%0t: %0d results never arrived", $time, expected_coils.size());
		if (mismatch_count == 0 && expected_coils.size() == 0) begin
			$display("two_axis_stepper_segment_driver verification clean");
		end else begin
			$display("two_axis_stepper_segment_driver verification failed");
		end
		$finish;
	end

endmodule
